// ===== rtl/core/fmpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fmpm_pkg
// Shared constants and types for the Fibonacci matrix-power core.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpm_pkg;

	localparam int unsigned INDEX_W = 63;
	localparam int unsigned VALUE_W = 30;

	// Modulus and Barrett constant: floor(2^60 / p)
	localparam logic [VALUE_W-1:0] PRIME      = 30'd1000000007;
	localparam logic [30:0]        BARRETT_MU = 31'd1152921496;
	localparam logic [31:0]        PRIME_X1   = 32'd1000000007;
	localparam logic [31:0]        PRIME_X2   = 32'd2000000014;

	typedef logic [VALUE_W-1:0] resid_t;

	// multiply-add-reduce request: res = (a*b + c) mod p
	typedef struct packed {
		logic   start;
		resid_t a;
		resid_t b;
		resid_t c;
	} mac_req_t;

	typedef struct packed {
		logic   done;
		resid_t res;
	} mac_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/fmpm_index_if.sv =====
// ----------------------------------------------------------------------------
// fmpm_index_if
// Input channel: one exponent per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmpm_index_if;

	logic                            valid;
	logic                            ready;
	logic [fmpm_pkg::INDEX_W-1:0]    index;

	modport source (output valid, output index, input ready);
	modport sink   (input valid, input index, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/fmpm_value_if.sv =====
// ----------------------------------------------------------------------------
// fmpm_value_if
// Output channel: one residue per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmpm_value_if;

	logic                            valid;
	logic                            ready;
	logic [fmpm_pkg::VALUE_W-1:0]    value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/fmpm_mac.sv =====
// ----------------------------------------------------------------------------
// fmpm_mac
// Multi-cycle (a*b + c) mod p on one shared 31x31 multiplier, Barrett reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpm_mac (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fmpm_pkg::mac_req_t req,
	output fmpm_pkg::mac_rsp_t      rsp
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_PROD,
		M_SUM,
		M_MU,
		M_QP,
		M_SUB,
		M_FIX,
		M_DONE
	} mstate_t;

	mstate_t          state_q;
	fmpm_pkg::resid_t a_q, b_q, c_q, res_q;
	logic [61:0]      prod_q;
	logic [59:0]      x_q;
	logic [31:0]      r_q;

	logic [30:0]      mul_a, mul_b;
	logic [61:0]      mul_p;
	logic [32:0]      r_m1, r_m2;
	fmpm_pkg::resid_t r_fix;

	// operand select for the one multiplier
	always_comb begin
		case (state_q)
			M_MU: begin
				mul_a = x_q[59:29];
				mul_b = fmpm_pkg::BARRETT_MU;
			end
			M_QP: begin
				mul_a = prod_q[61:31];	// quotient estimate
				mul_b = {1'b0, fmpm_pkg::PRIME};
			end
			default: begin
				mul_a = {1'b0, a_q};
				mul_b = {1'b0, b_q};
			end
		endcase
	end

	assign mul_p = {31'b0, mul_a} * {31'b0, mul_b};

	// remainder is below 3p: at most two subtractions
	assign r_m1 = {1'b0, r_q} - {1'b0, fmpm_pkg::PRIME_X1};
	assign r_m2 = {1'b0, r_q} - {1'b0, fmpm_pkg::PRIME_X2};

	always_comb begin
		if (!r_m2[32]) begin
			r_fix = r_m2[fmpm_pkg::VALUE_W-1:0];
		end else if (!r_m1[32]) begin
			r_fix = r_m1[fmpm_pkg::VALUE_W-1:0];
		end else begin
			r_fix = r_q[fmpm_pkg::VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						c_q     <= req.c;
						state_q <= M_PROD;
					end
				end
				M_PROD: begin
					prod_q  <= mul_p;
					state_q <= M_SUM;
				end
				M_SUM: begin
					x_q     <= prod_q[59:0] + {30'b0, c_q};
					state_q <= M_MU;
				end
				M_MU: begin
					prod_q  <= mul_p;
					state_q <= M_QP;
				end
				M_QP: begin
					prod_q  <= mul_p;
					state_q <= M_SUB;
				end
				M_SUB: begin
					r_q     <= x_q[31:0] - prod_q[31:0];
					state_q <= M_FIX;
				end
				M_FIX: begin
					res_q   <= r_fix;
					state_q <= M_DONE;
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (state_q == M_DONE);
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/fibonacci_mod_prime_matrix_power_core.sv =====
// ----------------------------------------------------------------------------
// fibonacci_mod_prime_matrix_power_core
// F(n+1) mod 1000000007 by square-and-multiply of [[1,1],[1,0]].
// ----------------------------------------------------------------------------
//
//   channel | dir | fields        | handshake
//   --------+-----+---------------+------------------------------
//   req     | in  | index [62:0]  | valid/ready, taken when both high
//   rsp     | out | value [29:0]  | valid/ready, taken when both high
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Every matrix entry term goes through the shared mac unit, and a 2x2 product
// takes eight terms. An item runs popcount(n) + msb(n) products (msb(n) is
// the position of the top set bit), and none for index zero.
// Reset clears the sequencer and the output valid; matrices are payload only.
// A result waiting on rsp holds the finish state until the slot frees.
//
`default_nettype none

module fibonacci_mod_prime_matrix_power_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fmpm_index_if.sink   req,
	fmpm_value_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FIN
	} state_t;

	// which product is running: acc*base or base*base
	typedef enum logic {
		PH_ACC,
		PH_SQR
	} phase_t;

	state_t                       state_q;
	phase_t                       phase_q;
	logic [2:0]                   step_q;	// {i, j, k}
	logic [fmpm_pkg::INDEX_W-1:0] n_q;
	fmpm_pkg::resid_t             run_q;	// partial sum of the current entry
	fmpm_pkg::resid_t             acc_q  [4];
	fmpm_pkg::resid_t             base_q [4];
	fmpm_pkg::resid_t             tmp_q  [4];
	fmpm_pkg::resid_t             fin_q;
	fmpm_pkg::resid_t             value_q;
	logic                         vld_q;

	fmpm_pkg::mac_req_t           mac_req;
	fmpm_pkg::mac_rsp_t           mac_rsp;

	logic [1:0]                   x_idx, y_idx;
	logic                         out_free;

	// left operand is entry (i,k), right operand entry (k,j)
	assign x_idx = {step_q[2], step_q[0]};
	assign y_idx = {step_q[0], step_q[1]};

	always_comb begin
		mac_req.start = (state_q == S_ISSUE);
		mac_req.a     = (phase_q == PH_ACC) ? acc_q[x_idx] : base_q[x_idx];
		mac_req.b     = base_q[y_idx];
		mac_req.c     = step_q[0] ? run_q : '0;
	end

	fmpm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	assign out_free  = !vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = vld_q;
	assign rsp.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_ACC;
			step_q  <= '0;
			vld_q   <= 1'b0;
		end else begin
			// load the output slot from the finish state, else drain it
			if (state_q == S_FIN && out_free) begin
				vld_q <= 1'b1;
			end else if (vld_q && rsp.ready) begin
				vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						n_q       <= req.index;
						step_q    <= '0;
						phase_q   <= req.index[0] ? PH_ACC : PH_SQR;
						// acc = identity, base = Q
						acc_q[0]  <= fmpm_pkg::resid_t'(1);
						acc_q[1]  <= '0;
						acc_q[2]  <= '0;
						acc_q[3]  <= fmpm_pkg::resid_t'(1);
						base_q[0] <= fmpm_pkg::resid_t'(1);
						base_q[1] <= fmpm_pkg::resid_t'(1);
						base_q[2] <= fmpm_pkg::resid_t'(1);
						base_q[3] <= '0;
						if (req.index == '0) begin
							fin_q   <= fmpm_pkg::resid_t'(1);
							state_q <= S_FIN;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end

				S_ISSUE: begin
					state_q <= S_WAIT;
				end

				S_WAIT: begin
					if (mac_rsp.done) begin
						step_q <= step_q + 3'd1;
						if (!step_q[0]) begin
							run_q   <= mac_rsp.res;
							state_q <= S_ISSUE;
						end else begin
							tmp_q[step_q[2:1]] <= mac_rsp.res;
							if (step_q == 3'd7) begin
								// product complete: commit it
								if (phase_q == PH_ACC) begin
									acc_q[0] <= tmp_q[0];
									acc_q[1] <= tmp_q[1];
									acc_q[2] <= tmp_q[2];
									acc_q[3] <= mac_rsp.res;
									if (n_q[fmpm_pkg::INDEX_W-1:1] == '0) begin
										// last set bit done, no more squaring
										fin_q   <= tmp_q[0];
										state_q <= S_FIN;
									end else begin
										phase_q <= PH_SQR;
										state_q <= S_ISSUE;
									end
								end else begin
									base_q[0] <= tmp_q[0];
									base_q[1] <= tmp_q[1];
									base_q[2] <= tmp_q[2];
									base_q[3] <= mac_rsp.res;
									n_q       <= n_q >> 1;
									phase_q   <= n_q[1] ? PH_ACC : PH_SQR;
									state_q   <= S_ISSUE;
								end
							end else begin
								state_q <= S_ISSUE;
							end
						end
					end
				end

				S_FIN: begin
					if (out_free) begin
						value_q <= fin_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
